### hw/rtl/lzss_window_decoder_macros.svh
// ----------------------------------------------------------------------------
// lzss_window_decoder_macros
// Assertion shorthands used by the decoder datapath.
// ----------------------------------------------------------------------------
`ifndef LZSS_WINDOW_DECODER_MACROS_SVH
`define LZSS_WINDOW_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define LZWD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define LZWD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// Types and constants shared by the LZSS window decoder modules.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    // History window
    localparam int unsigned WINDOW_SIZE = 1024;
    localparam int unsigned ADDR_W      = $clog2(WINDOW_SIZE);

    // Field and counter widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned BITS_W    = 4;
    localparam int unsigned LEN_W     = 7;
    localparam int unsigned NBYTES_W  = 2;
    localparam int unsigned POS_SUM_W = 11;

    // Token constants
    localparam logic [POS_SUM_W-1:0] POS_OFFSET   = POS_SUM_W'(66);
    localparam logic [LEN_W-1:0]     LEN_BIAS     = LEN_W'(3);
    localparam logic [BITS_W-1:0]    FLAG_COUNT   = BITS_W'(8);
    localparam logic [COUNT_W-1:0]   WINDOW_COUNT = COUNT_W'(WINDOW_SIZE);
    localparam logic [NBYTES_W-1:0]  NBYTES_ONE   = NBYTES_W'(1);
    localparam logic [NBYTES_W-1:0]  NBYTES_TWO   = NBYTES_W'(2);

    // What the next stream byte is expected to be
    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_ITEM  = 2'd1,
        PH_COPY2 = 2'd2
    } t_lzwd_phase;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_WRITE = 2'd2
    } t_lzwd_state;

    // Controller to datapath
    typedef struct packed {
        logic take_item;
        logic issue_read;
        logic write_byte;
    } t_lzwd_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic start_copy;
        logic last_byte;
        logic have_first;
    } t_lzwd_status;

endpackage

### hw/rtl/lzwd_ctrl.sv
// ----------------------------------------------------------------------------
// lzwd_ctrl
// Sequencer for the decoder: takes stream bytes and walks copy runs.
// ----------------------------------------------------------------------------
module lzwd_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lzwd_pkg::t_lzwd_status i_status,
    output lzwd_pkg::t_lzwd_cmd    o_cmd
);

    lzwd_pkg::t_lzwd_state r_state;
    lzwd_pkg::t_lzwd_state n_state;
    logic                  w_emit;

    // A write step emits when it completes a pair or ends the run
    assign w_emit = i_status.have_first || i_status.last_byte;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzwd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lzwd_pkg::ST_IDLE: begin
                if (i_status.start_copy) begin
                    n_state = lzwd_pkg::ST_READ;
                end
            end
            lzwd_pkg::ST_READ: begin
                n_state = lzwd_pkg::ST_WRITE;
            end
            lzwd_pkg::ST_WRITE: begin
                if (!w_emit || i_status.out_free) begin
                    n_state = i_status.last_byte ? lzwd_pkg::ST_IDLE : lzwd_pkg::ST_READ;
                end
            end
            default: begin
                n_state = lzwd_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            lzwd_pkg::ST_IDLE: begin
                o_cmd.take_item = i_status.out_free;
            end
            lzwd_pkg::ST_READ: begin
                o_cmd.issue_read = 1'b1;
            end
            lzwd_pkg::ST_WRITE: begin
                o_cmd.write_byte = !w_emit || i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### hw/rtl/lzwd_datapath.sv
// ----------------------------------------------------------------------------
// lzwd_datapath
// Token decode, history window, copy pointers and the output register.
// ----------------------------------------------------------------------------
`include "lzss_window_decoder_macros.svh"

module lzwd_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lzwd_pkg::t_lzwd_cmd                   i_cmd,
    output lzwd_pkg::t_lzwd_status                o_status,
    input  logic                                  s_axis_tvalid,
    input  logic [lzwd_pkg::BYTE_W-1:0]           s_axis_tdata,
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [23:0]                           m_axis_tdata,
    output logic                                  m_axis_tlast,
    output logic                                  m_axis_tuser,
    input  logic                                  i_cfg_valid,
    input  logic [lzwd_pkg::COUNT_W-1:0]          i_cfg_data
);

    // History window
    logic [lzwd_pkg::BYTE_W-1:0] r_hist [lzwd_pkg::WINDOW_SIZE];

    // Decoder state
    lzwd_pkg::t_lzwd_phase          r_phase,      n_phase;
    logic [lzwd_pkg::BYTE_W-1:0]    r_flag,       n_flag;
    logic [lzwd_pkg::BITS_W-1:0]    r_bits,       n_bits;
    logic [lzwd_pkg::BYTE_W-1:0]    r_copy_high,  n_copy_high;
    logic [lzwd_pkg::COUNT_W-1:0]   r_out_count,  n_out_count;
    logic                           r_full,       n_full;
    logic [lzwd_pkg::COUNT_W-1:0]   r_image_size;

    // Copy run
    logic [lzwd_pkg::ADDR_W-1:0]    r_loc,        n_loc;
    logic [lzwd_pkg::LEN_W-1:0]     r_len,        n_len;
    logic                           r_have_first, n_have_first;
    logic [lzwd_pkg::BYTE_W-1:0]    r_first,      n_first;
    logic [lzwd_pkg::BYTE_W-1:0]    r_rd_data;
    logic                           r_rd_zero;

    // Output register
    logic                           r_out_valid,  n_out_valid;
    logic [lzwd_pkg::BYTE_W-1:0]    r_out_first,  n_out_first;
    logic [lzwd_pkg::BYTE_W-1:0]    r_out_second, n_out_second;
    logic [lzwd_pkg::NBYTES_W-1:0]  r_out_nbytes, n_out_nbytes;
    logic                           r_out_last,   n_out_last;
    logic                           r_out_done,   n_out_done;

    // Working signals
    logic                           w_fire;
    logic                           w_new;
    logic                           w_skip;
    lzwd_pkg::t_lzwd_phase          w_e_phase;
    logic [lzwd_pkg::BYTE_W-1:0]    w_e_flag;
    logic [lzwd_pkg::BITS_W-1:0]    w_e_bits;
    logic [lzwd_pkg::BITS_W-1:0]    w_bits_dec;
    logic [lzwd_pkg::COUNT_W-1:0]   w_e_count;
    logic                           w_e_full;
    logic [lzwd_pkg::COUNT_W-1:0]   w_lit_count;
    logic [lzwd_pkg::COUNT_W-1:0]   w_wr_count;
    logic                           w_wr_done;
    logic                           w_last;
    logic [lzwd_pkg::BYTE_W-1:0]    w_byte;
    logic [lzwd_pkg::POS_SUM_W-1:0] w_pos_sum;
    logic                           w_out_free;
    logic                           w_push;
    logic                           w_start_copy;
    logic                           w_mem_we;
    logic [lzwd_pkg::ADDR_W-1:0]    w_mem_addr;
    logic [lzwd_pkg::BYTE_W-1:0]    w_mem_data;
    logic                           w_rd_zero;

    // Item transfer and the new-image clear applied ahead of it
    assign w_fire     = i_cmd.take_item && s_axis_tvalid;
    assign w_new      = s_axis_tuser;
    assign w_e_phase  = w_new ? lzwd_pkg::PH_FLAG : r_phase;
    assign w_e_flag   = w_new ? '0 : r_flag;
    assign w_e_bits   = w_new ? '0 : r_bits;
    assign w_e_count  = w_new ? '0 : r_out_count;
    assign w_e_full   = w_new ? 1'b0 : r_full;
    assign w_skip     = w_e_full || (w_e_count >= r_image_size);
    assign w_bits_dec = w_e_bits - lzwd_pkg::BITS_W'(1);
    assign w_lit_count = w_e_count + lzwd_pkg::COUNT_W'(1);

    // Copy position: ten token bits plus the fixed offset, wrapped to the window
    assign w_pos_sum = lzwd_pkg::POS_OFFSET
                     + {1'b0, r_copy_high[1:0], s_axis_tdata};

    // Copy byte: slots beyond the fill of this image read as zero
    assign w_byte     = r_rd_zero ? '0 : r_rd_data;
    assign w_wr_count = r_out_count + lzwd_pkg::COUNT_W'(1);
    assign w_wr_done  = w_wr_count >= r_image_size;
    assign w_last     = w_wr_done || (r_len == lzwd_pkg::LEN_W'(1));
    assign w_rd_zero  = (r_out_count < lzwd_pkg::WINDOW_COUNT)
                     && ({{(lzwd_pkg::COUNT_W - lzwd_pkg::ADDR_W){1'b0}}, r_loc}
                         >= r_out_count);

    assign w_out_free = !r_out_valid || m_axis_tready;

    // Next-state logic for decode, copy and output
    always_comb begin
        n_phase      = r_phase;
        n_flag       = r_flag;
        n_bits       = r_bits;
        n_copy_high  = r_copy_high;
        n_out_count  = r_out_count;
        n_full       = r_full;
        n_loc        = r_loc;
        n_len        = r_len;
        n_have_first = r_have_first;
        n_first      = r_first;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_first  = r_out_first;
        n_out_second = r_out_second;
        n_out_nbytes = r_out_nbytes;
        n_out_last   = r_out_last;
        n_out_done   = r_out_done;
        w_push       = 1'b0;
        w_start_copy = 1'b0;
        w_mem_we     = 1'b0;
        w_mem_addr   = r_out_count[lzwd_pkg::ADDR_W-1:0];
        w_mem_data   = w_byte;

        if (w_fire) begin
            n_phase     = w_e_phase;
            n_flag      = w_e_flag;
            n_bits      = w_e_bits;
            n_out_count = w_e_count;
            n_full      = w_e_full;
            if (w_skip) begin
                // Image complete: drop the byte
                n_full = 1'b1;
            end else begin
                case (w_e_phase)
                    lzwd_pkg::PH_ITEM: begin
                        n_flag = w_e_flag >> 1;
                        n_bits = w_bits_dec;
                        if (w_e_flag[0]) begin
                            // Literal: store and send as a single-byte result
                            n_out_count  = w_lit_count;
                            n_full       = w_lit_count >= r_image_size;
                            n_phase      = (w_bits_dec != '0) ? lzwd_pkg::PH_ITEM
                                                              : lzwd_pkg::PH_FLAG;
                            w_mem_we     = 1'b1;
                            w_mem_addr   = w_e_count[lzwd_pkg::ADDR_W-1:0];
                            w_mem_data   = s_axis_tdata;
                            w_push       = 1'b1;
                            n_out_valid  = 1'b1;
                            n_out_first  = s_axis_tdata;
                            n_out_second = '0;
                            n_out_nbytes = lzwd_pkg::NBYTES_ONE;
                            n_out_last   = 1'b1;
                            n_out_done   = w_lit_count >= r_image_size;
                        end else begin
                            n_copy_high = s_axis_tdata;
                            n_phase     = lzwd_pkg::PH_COPY2;
                        end
                    end
                    lzwd_pkg::PH_COPY2: begin
                        // Second token byte: load the copy run
                        w_start_copy = 1'b1;
                        n_loc        = w_pos_sum[lzwd_pkg::ADDR_W-1:0];
                        n_len        = {1'b0, r_copy_high[7:2]} + lzwd_pkg::LEN_BIAS;
                        n_have_first = 1'b0;
                        n_phase      = (w_e_bits != '0) ? lzwd_pkg::PH_ITEM
                                                        : lzwd_pkg::PH_FLAG;
                    end
                    default: begin
                        // Flag byte
                        n_flag  = s_axis_tdata;
                        n_bits  = lzwd_pkg::FLAG_COUNT;
                        n_phase = lzwd_pkg::PH_ITEM;
                    end
                endcase
            end
        end

        if (i_cmd.write_byte) begin
            // One copied byte: store, advance, and pair up for output
            n_out_count = w_wr_count;
            n_full      = w_wr_done;
            n_loc       = r_loc + lzwd_pkg::ADDR_W'(1);
            n_len       = r_len - lzwd_pkg::LEN_W'(1);
            w_mem_we    = 1'b1;
            if (r_have_first) begin
                w_push       = 1'b1;
                n_have_first = 1'b0;
                n_out_valid  = 1'b1;
                n_out_first  = r_first;
                n_out_second = w_byte;
                n_out_nbytes = lzwd_pkg::NBYTES_TWO;
                n_out_last   = w_last;
                n_out_done   = w_wr_done;
            end else if (w_last) begin
                w_push       = 1'b1;
                n_out_valid  = 1'b1;
                n_out_first  = w_byte;
                n_out_second = '0;
                n_out_nbytes = lzwd_pkg::NBYTES_ONE;
                n_out_last   = 1'b1;
                n_out_done   = w_wr_done;
            end else begin
                n_have_first = 1'b1;
                n_first      = w_byte;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= lzwd_pkg::PH_FLAG;
            r_flag       <= '0;
            r_bits       <= '0;
            r_copy_high  <= '0;
            r_out_count  <= '0;
            r_full       <= 1'b0;
            r_image_size <= lzwd_pkg::COUNT_W'(1);
            r_have_first <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_flag       <= n_flag;
            r_bits       <= n_bits;
            r_copy_high  <= n_copy_high;
            r_out_count  <= n_out_count;
            r_full       <= n_full;
            r_have_first <= n_have_first;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid) begin
                r_image_size <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_loc        <= n_loc;
        r_len        <= n_len;
        r_first      <= n_first;
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
        r_out_nbytes <= n_out_nbytes;
        r_out_last   <= n_out_last;
        r_out_done   <= n_out_done;
    end

    // History window: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_hist[w_mem_addr] <= w_mem_data;
        end
        if (i_cmd.issue_read) begin
            r_rd_data <= r_hist[r_loc];
            r_rd_zero <= w_rd_zero;
        end
    end

    // Status
    assign o_status.out_free   = w_out_free;
    assign o_status.start_copy = w_start_copy;
    assign o_status.last_byte  = w_last;
    assign o_status.have_first = r_have_first;

    // Output channel
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_nbytes, r_out_second, r_out_first};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_done;

    // Checks
    `LZWD_ASSERT_IMP(a_no_overwrite, r_out_valid && !m_axis_tready, !w_push,
        "result loaded over a stalled result")
    `LZWD_ASSERT_IMP(a_len_live, i_cmd.write_byte, r_len != '0,
        "copy step with no length left")
    `LZWD_ASSERT_IMP(a_full_quiet, r_full && !(w_fire && w_new), !w_push,
        "result produced after the image completed")
    `LZWD_ASSERT_NXT(a_read_then_write, i_cmd.issue_read, !i_cmd.take_item,
        "item taken while a copy read is in flight")

endmodule

### hw/rtl/lzss_window_decoder.sv
// ----------------------------------------------------------------------------
// lzss_window_decoder
// LZSS stream decoder with a 1024-byte history window, up to two bytes per result.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one compressed byte per transfer; tuser set starts a new
//    image (token phase and output count cleared before the byte is used).
//  - m_axis carries decoded bytes, one or two per transfer; tlast marks the
//    final result caused by one input byte, tuser the image's final byte.
//  - cfg writes image_size; write only while no item is in flight.
//  - Flag bytes and first copy-token bytes produce no result.
//  - A literal's result is registered and shows on m_axis the next cycle.
//  - A copy run begins after the second token byte: each byte is a history
//    read state then a write state, which waits while a result it emits cannot
//    load; the window has separate read and write ports. The input is held off until the run ends.
//  - A stalled m_axis holds its result; a new result waits and s_axis_tready
//    drops while the output register is held.
//  - Reset clears token state and output count and sets image_size to 1;
//    window contents are not cleared, unwritten slots of an image read as 0.
// ----------------------------------------------------------------------------
module lzss_window_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] new_image
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] byte_first, [15:8] byte_second,
                                        // [17:16] byte_count, [23:18] zero
    output logic        m_axis_tlast,   // run_last
    output logic        m_axis_tuser,   // [0] image_done
    // Configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data      // image_size
);

    lzwd_pkg::t_lzwd_cmd    w_cmd;
    lzwd_pkg::t_lzwd_status w_status;

    // Controller
    lzwd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Datapath
    lzwd_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data)
    );

    // Accept bytes only between copy runs with room in the output register
    assign s_axis_tready = w_cmd.take_item;
    assign o_cfg_ready   = 1'b1;

endmodule
